/* src/qpd_pkg.sv */
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared constants and types for the quaternion PD torque block.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;

  // mounting quaternion, Q1.14
  localparam logic signed [15:0] MNT_W = 16'sd14428;
  localparam logic signed [15:0] MNT_X = 16'sd5974;
  localparam logic signed [15:0] MNT_Y = -16'sd4579;
  localparam logic signed [15:0] MNT_Z = 16'sd1901;

  // transposed rotation matrix of the mounting quaternion, Q1.14
  localparam logic signed [15:0] ROT_T [3][3] = '{
    '{16'sd13383, 16'sd8, 16'sd9451},
    '{-16'sd6686, 16'sd11587, 16'sd9458},
    '{-16'sd6679, -16'sd11583, 16'sd9468}
  };

  localparam logic [2:0] REG_KP  = 3'd0;
  localparam logic [2:0] REG_KD  = 3'd1;
  localparam logic [2:0] REG_TRX = 3'd2;
  localparam logic [2:0] REG_TRY = 3'd3;
  localparam logic [2:0] REG_TRZ = 3'd4;

  localparam logic [47:0] KP_RESET = 48'h010001000100;

  typedef logic signed [31:0] torque_t;

endpackage

/* src/qpd_mount.sv */
// ----------------------------------------------------------------------------
// qpd_mount
// Two-stage Hamilton product q * m: registered products, then rounded sum.
// ----------------------------------------------------------------------------
module qpd_mount #(
  parameter int SW = qpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en0,
  input  logic                 en1,
  input  logic signed [SW-1:0] q_w,
  input  logic signed [SW-1:0] q_x,
  input  logic signed [SW-1:0] q_y,
  input  logic signed [SW-1:0] q_z,
  output logic signed [SW-1:0] p_w,
  output logic signed [SW-1:0] p_x,
  output logic signed [SW-1:0] p_y,
  output logic signed [SW-1:0] p_z
);
  import qpd_pkg::*;

  localparam int PW = SW + 16;
  localparam int SUMW = PW + 2;

  logic signed [PW-1:0] pr_r [16];
  logic signed [PW-1:0] pr_nxt [16];
  logic signed [SUMW-1:0] s [4];
  logic signed [SW-1:0] p_nxt [4];
  logic signed [SW-1:0] p_r [4];

  always_comb begin
    pr_nxt[0]  = PW'(q_w * MNT_W);  pr_nxt[1]  = PW'(q_x * MNT_X);
    pr_nxt[2]  = PW'(q_y * MNT_Y);  pr_nxt[3]  = PW'(q_z * MNT_Z);
    pr_nxt[4]  = PW'(q_w * MNT_X);  pr_nxt[5]  = PW'(q_x * MNT_W);
    pr_nxt[6]  = PW'(q_y * MNT_Z);  pr_nxt[7]  = PW'(q_z * MNT_Y);
    pr_nxt[8]  = PW'(q_w * MNT_Y);  pr_nxt[9]  = PW'(q_x * MNT_Z);
    pr_nxt[10] = PW'(q_y * MNT_W);  pr_nxt[11] = PW'(q_z * MNT_X);
    pr_nxt[12] = PW'(q_w * MNT_Z);  pr_nxt[13] = PW'(q_x * MNT_Y);
    pr_nxt[14] = PW'(q_y * MNT_X);  pr_nxt[15] = PW'(q_z * MNT_W);
  end

  always_comb begin
    s[0] = SUMW'(pr_r[0]) - SUMW'(pr_r[1]) - SUMW'(pr_r[2]) - SUMW'(pr_r[3]);
    s[1] = SUMW'(pr_r[4]) + SUMW'(pr_r[5]) + SUMW'(pr_r[6]) - SUMW'(pr_r[7]);
    s[2] = SUMW'(pr_r[8]) - SUMW'(pr_r[9]) + SUMW'(pr_r[10]) + SUMW'(pr_r[11]);
    s[3] = SUMW'(pr_r[12]) + SUMW'(pr_r[13]) - SUMW'(pr_r[14]) + SUMW'(pr_r[15]);
  end

  // round half up, then clamp to SW bits
  for (genvar i = 0; i < 4; i++) begin : g_rnd
    logic signed [SUMW-1:0] rs;
    logic signed [SUMW-15:0] sh;
    localparam logic signed [SUMW-15:0] HI = (SUMW-14)'((1 <<< (SW-1)) - 1);
    localparam logic signed [SUMW-15:0] LO = -HI - 1;
    always_comb begin
      rs = s[i] + SUMW'(8192);
      sh = rs[SUMW-1:14];
      if (sh > HI)      p_nxt[i] = HI[SW-1:0];
      else if (sh < LO) p_nxt[i] = LO[SW-1:0];
      else              p_nxt[i] = sh[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en0) pr_r <= pr_nxt;
    if (en1) p_r <= p_nxt;
  end

  assign p_w = p_r[0];
  assign p_x = p_r[1];
  assign p_y = p_r[2];
  assign p_z = p_r[3];

endmodule

/* src/qpd_axis.sv */
// ----------------------------------------------------------------------------
// qpd_axis
// Per-axis error terms and torque law, spread over stages 3 to 6.
// ----------------------------------------------------------------------------
module qpd_axis #(
  parameter int SW = qpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic [3:0]           en,     // enables of stages 3..6 (top en[5:2])
  input  logic signed [SW-1:0] pa_w,
  input  logic signed [SW-1:0] pa_1,
  input  logic signed [SW-1:0] pa_2,
  input  logic signed [SW-1:0] pa_3,   // own axis, next, next-next
  input  logic signed [SW-1:0] pd_w,
  input  logic signed [SW-1:0] pd_1,
  input  logic signed [SW-1:0] pd_2,
  input  logic signed [SW-1:0] pd_3,
  input  logic signed [SW+17:0] rot,   // rotated rate, Q.14 of the rate unit, already summed
  input  logic signed [15:0]   trate,
  input  logic [15:0]          kp,
  input  logic [15:0]          kd,
  output qpd_pkg::torque_t     torque
);
  import qpd_pkg::*;

  localparam int EW = 2*SW + 2;
  localparam int RW = SW + 18;

  logic signed [2*SW-1:0] m_r [4];
  logic signed [EW-1:0] es;
  logic signed [EW-1:0] er;
  logic signed [31:0] e_r, e_nxt;
  logic signed [RW-1:0] rr;
  logic signed [RW:0] dwf;
  logic signed [31:0] dw_r, dw_nxt;
  logic signed [48:0] pk_r, pd_r;
  logic signed [55:0] t;
  logic signed [49:0] tsh;
  torque_t t_nxt, t_r;

  // stage 3: cross products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r[0] <= pa_w * pd_1;
      m_r[1] <= pd_w * pa_1;
      m_r[2] <= pa_2 * pd_3;
      m_r[3] <= pa_3 * pd_2;
    end
  end

  // stage 4: sum, round, clamp both errors
  always_comb begin
    es = EW'(m_r[0]) - EW'(m_r[1]) - EW'(m_r[2]) + EW'(m_r[3]);
    er = (es + EW'(8192)) >>> 14;
    if (er > EW'(32'sh7fffffff))       e_nxt = 32'sh7fffffff;
    else if (er < -EW'(32'sh7fffffff) - EW'(1)) e_nxt = 32'sh80000000;
    else                               e_nxt = er[31:0];
    rr  = (rot + RW'(8192)) >>> 14;
    dwf = -(RW+1)'(rr) - (RW+1)'(trate);
    if (dwf > (RW+1)'(32'sh7fffffff))  dw_nxt = 32'sh7fffffff;
    else if (dwf < -(RW+1)'(32'sh7fffffff) - (RW+1)'(1)) dw_nxt = 32'sh80000000;
    else                               dw_nxt = dwf[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      e_r  <= e_nxt;
      dw_r <= dw_nxt;
    end
  end

  // stage 5: gain products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pk_r <= $signed({1'b0, kp}) * e_r;
      pd_r <= $signed({1'b0, kd}) * dw_r;
    end
  end

  // stage 6: combine, round, clamp
  always_comb begin
    t   = -56'(pk_r) - (56'(pd_r) <<< 6) + 56'sd32;
    tsh = t[55:6];
    if (tsh > 50'sh7fffffff)        t_nxt = 32'sh7fffffff;
    else if (tsh < -50'sh80000000)  t_nxt = 32'sh80000000;
    else                            t_nxt = tsh[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) t_r <= t_nxt;
  end

  assign torque = t_r;

endmodule

/* src/qpd_rate.sv */
// ----------------------------------------------------------------------------
// qpd_rate
// Rotate the body rate by the transposed mounting matrix (two stages).
// ----------------------------------------------------------------------------
module qpd_rate #(
  parameter int SW = qpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic [1:0]            en,
  input  logic signed [SW-1:0]  w_x,
  input  logic signed [SW-1:0]  w_y,
  input  logic signed [SW-1:0]  w_z,
  output logic signed [SW+17:0] rot [3]
);
  import qpd_pkg::*;

  logic signed [SW+15:0] pr_r [3][3];
  logic signed [SW+17:0] rot_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (en[0]) begin
        pr_r[k][0] <= w_x * ROT_T[k][0];
        pr_r[k][1] <= w_y * ROT_T[k][1];
        pr_r[k][2] <= w_z * ROT_T[k][2];
      end
      if (en[1])
        rot_r[k] <= (SW+18)'(pr_r[k][0]) + (SW+18)'(pr_r[k][1]) + (SW+18)'(pr_r[k][2]);
    end
  end

  assign rot = rot_r;

endmodule

/* src/quaternion_pd_attitude_torque.sv */
// ----------------------------------------------------------------------------
// quaternion_pd_attitude_torque
// Quaternion PD attitude controller, torque stage.
// ----------------------------------------------------------------------------
// Fully pipelined: one word per clock in, one torque word per clock out while
// the output is not stalled, with six register stages from accepted input to
// output register. The pipeline advances whenever its last stage is empty or
// taken, so back-pressure stalls all stages together without loss.
module quaternion_pd_attitude_torque #(
  parameter int SAMPLE_WIDTH = qpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // actual_q_w,x,y,z, desired_q_w,x,y,z, rate_x,y,z (SAMPLE_WIDTH each)
  input  logic [((11*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // torque_x, torque_y, torque_z
  output logic [95:0]             out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [47:0]             cfg_data
);
  import qpd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int NST = 6;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  logic adv;
  logic [47:0] kp_r, kd_r;
  logic signed [15:0] tr_r [3];
  logic signed [SW-1:0] f [11];
  logic signed [SW-1:0] pa [4];
  logic signed [SW-1:0] pd [4];
  logic signed [SW+17:0] rot [3];
  torque_t tq [3];

  assign adv       = !vld_r[NST-1] || out_tready;
  assign in_tready = adv && rst_n;
  assign cfg_ready = rst_n;
  assign out_tvalid = vld_r[NST-1];

  always_comb begin
    en[0] = adv && in_tvalid;
    for (int i = 1; i < NST; i++) en[i] = adv && vld_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= KP_RESET;
      kd_r <= '0;
      tr_r <= '{default: '0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP:  kp_r <= cfg_data;
        REG_KD:  kd_r <= cfg_data;
        REG_TRX: tr_r[0] <= cfg_data[15:0];
        REG_TRY: tr_r[1] <= cfg_data[15:0];
        REG_TRZ: tr_r[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 11; i++) begin : g_f
    assign f[i] = in_tdata[i*SW +: SW];
  end

  qpd_mount #(.SW(SW)) u_ma (
    .clk(clk), .en0(en[0]), .en1(en[1]),
    .q_w(f[0]), .q_x(f[1]), .q_y(f[2]), .q_z(f[3]),
    .p_w(pa[0]), .p_x(pa[1]), .p_y(pa[2]), .p_z(pa[3])
  );
  qpd_mount #(.SW(SW)) u_md (
    .clk(clk), .en0(en[0]), .en1(en[1]),
    .q_w(f[4]), .q_x(f[5]), .q_y(f[6]), .q_z(f[7]),
    .p_w(pd[0]), .p_x(pd[1]), .p_y(pd[2]), .p_z(pd[3])
  );
  qpd_rate #(.SW(SW)) u_rate (
    .clk(clk), .en(en[1:0]), .w_x(f[8]), .w_y(f[9]), .w_z(f[10]), .rot(rot)
  );

  // align rotated rate with the quaternion path (held for stage 4)
  logic signed [SW+17:0] rot_d [3];
  always_ff @(posedge clk) begin
    if (en[2]) rot_d <= rot;
  end

  for (genvar k = 0; k < 3; k++) begin : g_ax
    qpd_axis #(.SW(SW)) u_ax (
      .clk(clk), .en(en[5:2]),
      .pa_w(pa[0]), .pa_1(pa[1+k]), .pa_2(pa[1+(k+1)%3]), .pa_3(pa[1+(k+2)%3]),
      .pd_w(pd[0]), .pd_1(pd[1+k]), .pd_2(pd[1+(k+1)%3]), .pd_3(pd[1+(k+2)%3]),
      .rot(rot_d[k]), .trate(tr_r[k]),
      .kp(kp_r[16*k +: 16]), .kd(kd_r[16*k +: 16]),
      .torque(tq[k])
    );
  end

  assign out_tdata = {tq[2], tq[1], tq[0]};

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the quaternion PD torque stage: directed extremes,
// random attitudes with each Q1.14 part in [-1, 1) and raw noise, under several gain and
// target-rate settings, with random idling on both sides of the block.
// ----------------------------------------------------------------------------

class torque_scoreboard;
  logic [47:0]        prop_gain_word;
  logic [47:0]        rate_gain_word;
  logic signed [15:0] target_rate [3];
  logic [95:0]        torque_pending [$];
  int                 mismatches;
  int                 words_checked;

  function void reset_regs();
    prop_gain_word = qpd_pkg::KP_RESET;
    rate_gain_word = '0;
    target_rate = '{default: '0};
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] val);
    case (idx)
      qpd_pkg::REG_KP:  prop_gain_word = val;
      qpd_pkg::REG_KD:  rate_gain_word = val;
      qpd_pkg::REG_TRX: target_rate[0] = val[15:0];
      qpd_pkg::REG_TRY: target_rate[1] = val[15:0];
      qpd_pkg::REG_TRZ: target_rate[2] = val[15:0];
      default: ;
    endcase
  endfunction

  // saturating add in 64 bits, lower bound -max
  function longint sat_add(longint a, longint b);
    longint maxv;
    maxv = 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b > 0 && a > maxv - b) return maxv;
    if (b < 0 && a < -maxv - b) return -maxv;
    return a + b;
  endfunction

  function longint clamp_bits(longint x, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // round half up, floor division by 2^n
  function longint round_shift(longint x, int n);
    x = sat_add(x, 64'sd1 <<< (n - 1));
    return x >>> n;
  endfunction

  function void mount_rotate(longint q [4], output longint p [4]);
    longint s [4];
    longint mw, mx, my, mz;
    mw = qpd_pkg::MNT_W; mx = qpd_pkg::MNT_X;
    my = qpd_pkg::MNT_Y; mz = qpd_pkg::MNT_Z;
    s[0] = q[0]*mw - q[1]*mx - q[2]*my - q[3]*mz;
    s[1] = q[0]*mx + q[1]*mw + q[2]*mz - q[3]*my;
    s[2] = q[0]*my - q[1]*mz + q[2]*mw + q[3]*mx;
    s[3] = q[0]*mz + q[1]*my - q[2]*mx + q[3]*mw;
    for (int i = 0; i < 4; i++) p[i] = clamp_bits(round_shift(s[i], 14), 16);
  endfunction

  function void note_input(logic [175:0] word);
    longint qa [4], qd [4], pa [4], pd [4], w [3];
    longint e, r, dw, kp, kd, t;
    int a1, a2;
    logic [95:0] res;
    for (int i = 0; i < 4; i++) begin
      qa[i] = $signed(word[16*i +: 16]);
      qd[i] = $signed(word[16*(4+i) +: 16]);
    end
    for (int i = 0; i < 3; i++) w[i] = $signed(word[16*(8+i) +: 16]);
    mount_rotate(qa, pa);
    mount_rotate(qd, pd);
    for (int k = 0; k < 3; k++) begin
      a1 = 1 + (k + 1) % 3;
      a2 = 1 + (k + 2) % 3;
      e = pa[0] * pd[1+k];
      e = sat_add(e, -(pd[0] * pa[1+k]));
      e = sat_add(e, -(pa[a1] * pd[a2]));
      e = sat_add(e, pa[a2] * pd[a1]);
      e = clamp_bits(round_shift(e, 14), 32);
      r = 0;
      for (int j = 0; j < 3; j++) r += longint'(qpd_pkg::ROT_T[k][j]) * w[j];
      dw = clamp_bits(-round_shift(r, 14) - longint'(target_rate[k]), 32);
      kp = prop_gain_word[16*k +: 16];
      kd = rate_gain_word[16*k +: 16];
      t = -(kp * e) - kd * dw * 64;
      t = clamp_bits(round_shift(t, 6), 32);
      res[32*k +: 32] = t[31:0];
    end
    torque_pending.push_back(res);
  endfunction

  task report(string what, logic [95:0] got, logic [95:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s: got %h want %h", what, got, want);
  endtask

  task check_result(logic [95:0] got);
    logic [95:0] want;
    words_checked++;
    if (torque_pending.size() == 0) begin
      report("unexpected torque word", got, 'x);
      return;
    end
    want = torque_pending.pop_front();
    for (int k = 0; k < 3; k++)
      if (got[32*k +: 32] !== want[32*k +: 32])
        report($sformatf("torque axis %0d", k), got, want);
  endtask
endclass

module tb_top;
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  torque_scoreboard torque_sb;
  int  cycle_count = 0;
  bit  idle_allowed = 1'b1;
  int  items_sent = 0;
  localparam int CYCLE_LIMIT = 200000;

  quaternion_pd_attitude_torque DUT (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver: sample on the edge, then pick the next ready
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) torque_sb.check_result(out_tdata);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // valid stays high after an accept; a gap or drain drops it
  task automatic send_word(logic [175:0] word);
    int gap;
    if (idle_allowed && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    torque_sb.note_input(word);
    items_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    torque_sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (torque_sb.torque_pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [15:0] near_unit_part();
    return 16'($signed($urandom_range(0, 32767)) - 16384);
  endfunction

  function automatic logic [175:0] random_word(bit well_formed);
    logic [175:0] word;
    for (int i = 0; i < 11; i++) word[16*i +: 16] = 16'($urandom());
    if (well_formed) begin
      for (int i = 0; i < 8; i++) word[16*i +: 16] = near_unit_part();
      for (int i = 8; i < 11; i++)
        word[16*i +: 16] = 16'($signed($urandom_range(0, 2047)) - 1024);
    end
    return word;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_word(random_word($urandom_range(0, 3) != 0));
  endtask

  task automatic config_all(logic [47:0] kp, logic [47:0] kd,
                            logic [15:0] tx, logic [15:0] ty, logic [15:0] tz);
    write_reg(qpd_pkg::REG_KP, kp);
    write_reg(qpd_pkg::REG_KD, kd);
    write_reg(qpd_pkg::REG_TRX, tx);
    write_reg(qpd_pkg::REG_TRY, ty);
    write_reg(qpd_pkg::REG_TRZ, tz);
  endtask

  initial begin
    torque_sb = new();
    torque_sb.reset_regs();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, extremes, zero, alternating bit patterns
    send_word({48'h0, 16'h0, 16'h0, 16'h0, 16'd16384, 16'h0, 16'h0, 16'h0, 16'd16384});
    send_word('0);
    send_word({11{16'h7FFF}});
    send_word({11{16'h8000}});
    send_word({11{16'hFFFF}});
    send_word({11{16'h5555}});
    send_word({11{16'hAAAA}});
    send_word({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
               16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    drain();
    // maximum gains and extreme targets drive torque into saturation
    config_all('1, '1, 16'h7FFF, 16'h8000, 16'h8000);
    send_word({11{16'h7FFF}});
    send_word({11{16'h8000}});
    send_word({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
               16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_word('0);
    random_phase(300);
    drain();
    config_all('0, '0, 16'h0, 16'h0, 16'h0);
    send_word({11{16'h7FFF}});
    random_phase(100);
    drain();
    for (int p = 0; p < 3; p++) begin
      config_all(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      write_reg(3'd5 + 3'(p), 48'({$urandom(), $urandom()}));
      random_phase(250);
      drain();
    end
    write_reg(3'd7, '1);
    config_all(48'h010001000100, 48'h004000400040, 16'h0100, 16'hFF00, 16'h0080);
    idle_allowed = 1'b0;
    random_phase(150);
    drain();

    $display("covered %0d input words, %0d torque words, several register settings",
             items_sent, torque_sb.words_checked);
    if (torque_sb.mismatches == 0 && torque_sb.torque_pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0d mismatches", torque_sb.mismatches);
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
